// ----- hw/rtl/lccs_pkg.sv -----
// Package for the LED and camera capture sequencer.
// Types, codes and constants shared by lccs_core and the top level.
// No dependencies.
`timescale 1ns / 1ps

package lccs_pkg;

   localparam int MAX_LED     = 8;
   localparam int SEQ_DEPTH   = 16;
   localparam int TIME_BITS   = 24;
   localparam int REG_W       = 24;
   localparam int LED_ID_W    = 4;
   localparam int IDX_W       = 4;
   localparam int TABLE_DEPTH = 16;
   localparam int MASK_W      = 8;
   localparam int LIT_W       = MAX_LED;
   localparam int CSR_IDX_W   = 3;

   localparam logic [REG_W-1:0] PULSE_RESET  = REG_W'(100);
   localparam logic [REG_W-1:0] SETTLE_RESET = REG_W'(50);

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_CLEAR   = 3'd1,
      OP_LOAD    = 3'd2,
      OP_SEQ     = 3'd3,
      OP_CAPTURE = 3'd4,
      OP_FOCUS   = 3'd5,
      OP_LIGHT   = 3'd6,
      OP_DARK    = 3'd7
   } opcode_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_LSETTLE   = 4'd1,
      PH_FSETTLE   = 4'd2,
      PH_SSTART    = 4'd3,
      PH_SOVERLAP  = 4'd4,
      PH_SPREFOCUS = 4'd5,
      PH_FOCUS     = 4'd6,
      PH_PULSE     = 4'd7,
      PH_SHUTWAIT  = 4'd8,
      PH_AFTER     = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      MODE_LIGHT   = 2'd0,
      MODE_CAPTURE = 2'd1,
      MODE_FOCUS   = 2'd2,
      MODE_SEQ     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      COLOR_GREEN  = 3'd0,
      COLOR_BLUE   = 3'd1,
      COLOR_OFF    = 3'd2,
      COLOR_PURPLE = 3'd3,
      COLOR_ORANGE = 3'd4
   } color_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_BUSY  = 2'd1,
      ERR_LED   = 2'd2,
      ERR_INDEX = 2'd3
   } error_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OVERLAP  = 3'd0,
      CSR_PREFOCUS = 3'd1,
      CSR_FOCUS    = 3'd2,
      CSR_SHUTWAIT = 3'd3,
      CSR_AFTER    = 3'd4,
      CSR_PULSE    = 3'd5,
      CSR_SETTLE   = 3'd6,
      CSR_SPARE    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0]          opcode;
      logic [LED_ID_W-1:0] led_id;
      logic [IDX_W-1:0]    entry_index;
   } req_payload_type;

   typedef struct packed {
      logic [MASK_W-1:0] led_mask;
      logic              focus_out;
      logic              shutter_out;
      logic              busy_res;
      logic [2:0]        status_color;
      logic [1:0]        error;
   } rsp_payload_type;

   typedef struct packed {
      logic [REG_W-1:0] overlap_ticks;
      logic [REG_W-1:0] prefocus_ticks;
      logic [REG_W-1:0] focus_ticks;
      logic [REG_W-1:0] shutter_wait_ticks;
      logic [REG_W-1:0] after_ticks;
      logic [REG_W-1:0] pulse_ticks;
      logic [REG_W-1:0] settle_ticks;
   } timing_cfg_type;

   // One-hot lamp bit for an LED id; id zero or out of range gives no bit.
   function automatic logic [LIT_W-1:0] led_bit(input logic [LED_ID_W-1:0] id);
      logic [LIT_W-1:0] b;
      b = '0;
      for (int i = 0; i < LIT_W; i++) begin
         b[i] = (32'(id) == i + 1);
      end
      return b;
   endfunction

   function automatic logic [TIME_BITS-1:0] to_time(input logic [REG_W-1:0] d);
      return TIME_BITS'(d);
   endfunction

endpackage

// ----- hw/rtl/lccs_core.sv -----
// Sequencer state and next-state logic for the LED and camera controller.
// Depends on lccs_pkg. Updates its state on each accepted transaction and
// presents the result for that transaction combinationally.
`timescale 1ns / 1ps

module lccs_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  lccs_pkg::req_payload_type item,
   input  lccs_pkg::timing_cfg_type  cfg,
   output lccs_pkg::rsp_payload_type result
);
   import lccs_pkg::*;

   logic [LED_ID_W-1:0]  table_ff [TABLE_DEPTH];
   logic [LED_ID_W-1:0]  table_in [TABLE_DEPTH];
   logic [IDX_W-1:0]     last_nz_ff, last_nz_in;
   logic [LIT_W-1:0]     lit_ff, lit_in;
   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] count_ff, count_in;
   logic [IDX_W-1:0]     step_ff, step_in;
   mode_type             mode_ff, mode_in;
   logic [LED_ID_W-1:0]  target_ff, target_in;
   logic                 focus_ff, focus_in;
   logic                 shutter_ff, shutter_in;
   // LED ids of the current and previous sequence steps
   logic [LED_ID_W-1:0]  cur_led_ff, cur_led_in;
   logic [LED_ID_W-1:0]  prev_led_ff, prev_led_in;

   logic [IDX_W-1:0]     rd_addr;
   logic [LED_ID_W-1:0]  rd_led;
   error_type            err;
   color_type            color;
   logic                 led_bad;
   logic                 lit_hit;

   assign rd_addr = (phase_ff == PH_SSTART) ? '0 : step_ff + IDX_W'(1);
   assign rd_led  = table_ff[rd_addr];
   assign led_bad = 32'(item.led_id) > MAX_LED;
   assign lit_hit = |(lit_ff & led_bit(item.led_id));

   always_comb begin
      table_in    = table_ff;
      last_nz_in  = last_nz_ff;
      lit_in      = lit_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      step_in     = step_ff;
      mode_in     = mode_ff;
      target_in   = target_ff;
      focus_in    = focus_ff;
      shutter_in  = shutter_ff;
      cur_led_in  = cur_led_ff;
      prev_led_in = prev_led_ff;
      err         = ERR_NONE;

      if (item.opcode == OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            if (count_ff > TIME_BITS'(1)) begin
               count_in = count_ff - TIME_BITS'(1);
            end else begin
               unique case (phase_ff)
                  PH_LSETTLE: begin
                     lit_in = lit_ff | led_bit(target_ff);
                     if (mode_ff == MODE_CAPTURE) begin
                        focus_in = 1'b1;
                        phase_in = PH_FOCUS;
                        count_in = to_time(cfg.focus_ticks);
                     end else if (mode_ff == MODE_FOCUS) begin
                        phase_in = PH_FSETTLE;
                        count_in = to_time(cfg.settle_ticks);
                     end else begin
                        phase_in = PH_IDLE;
                        count_in = '0;
                     end
                  end
                  PH_FSETTLE, PH_SPREFOCUS: begin
                     focus_in = 1'b1;
                     phase_in = PH_FOCUS;
                     count_in = to_time(cfg.focus_ticks);
                  end
                  PH_SSTART: begin
                     step_in    = '0;
                     lit_in     = lit_ff | led_bit(rd_led);
                     cur_led_in = rd_led;
                     phase_in   = PH_SOVERLAP;
                     count_in   = to_time(cfg.overlap_ticks);
                  end
                  PH_SOVERLAP: begin
                     if (step_ff != '0) begin
                        lit_in = lit_ff & ~led_bit(prev_led_ff);
                     end
                     phase_in = PH_SPREFOCUS;
                     count_in = to_time(cfg.prefocus_ticks);
                  end
                  PH_FOCUS: begin
                     if (mode_ff == MODE_FOCUS) begin
                        focus_in   = 1'b0;
                        shutter_in = 1'b0;
                        phase_in   = PH_IDLE;
                        count_in   = '0;
                     end else begin
                        shutter_in = 1'b1;
                        phase_in   = PH_PULSE;
                        count_in   = to_time(cfg.pulse_ticks);
                     end
                  end
                  PH_PULSE: begin
                     shutter_in = 1'b0;
                     focus_in   = 1'b0;
                     phase_in   = PH_SHUTWAIT;
                     count_in   = to_time(cfg.shutter_wait_ticks);
                  end
                  PH_SHUTWAIT: begin
                     phase_in = PH_AFTER;
                     count_in = to_time(cfg.after_ticks);
                  end
                  PH_AFTER: begin
                     if (mode_ff == MODE_SEQ && step_ff < last_nz_ff) begin
                        step_in     = step_ff + IDX_W'(1);
                        lit_in      = lit_ff | led_bit(rd_led);
                        prev_led_in = cur_led_ff;
                        cur_led_in  = rd_led;
                        phase_in    = PH_SOVERLAP;
                        count_in    = to_time(cfg.overlap_ticks);
                     end else begin
                        // the final step always sits at last_nz, so its LED is cur_led
                        if (mode_ff == MODE_SEQ) begin
                           lit_in = lit_ff & ~led_bit(cur_led_ff);
                        end
                        phase_in = PH_IDLE;
                        count_in = '0;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     count_in = '0;
                  end
               endcase
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         err = ERR_BUSY;
      end else begin
         unique case (item.opcode)
            OP_CLEAR: begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  table_in[i] = '0;
               end
               last_nz_in = '0;
            end
            OP_LOAD: begin
               if (32'(item.entry_index) >= SEQ_DEPTH) begin
                  err = ERR_INDEX;
               end else if (led_bad) begin
                  err = ERR_LED;
               end else begin
                  table_in[item.entry_index] = item.led_id;
                  last_nz_in = '0;
                  for (int i = 0; i < SEQ_DEPTH; i++) begin
                     if (table_in[i] != '0) begin
                        last_nz_in = IDX_W'(i);
                     end
                  end
               end
            end
            OP_SEQ: begin
               mode_in  = MODE_SEQ;
               step_in  = '0;
               lit_in   = '0;
               phase_in = PH_SSTART;
               count_in = to_time(cfg.overlap_ticks);
            end
            OP_DARK: begin
               lit_in = '0;
            end
            OP_CAPTURE, OP_FOCUS, OP_LIGHT: begin
               if (led_bad) begin
                  err = ERR_LED;
               end else begin
                  case (item.opcode)
                     OP_CAPTURE: mode_in = MODE_CAPTURE;
                     OP_FOCUS:   mode_in = MODE_FOCUS;
                     default:    mode_in = MODE_LIGHT;
                  endcase
                  target_in = item.led_id;
                  if (lit_hit) begin
                     // already lit: skip straight past the light step
                     if (mode_in == MODE_CAPTURE) begin
                        focus_in = 1'b1;
                        phase_in = PH_FOCUS;
                        count_in = to_time(cfg.focus_ticks);
                     end else if (mode_in == MODE_FOCUS) begin
                        phase_in = PH_FSETTLE;
                        count_in = to_time(cfg.settle_ticks);
                     end else begin
                        phase_in = PH_IDLE;
                        count_in = '0;
                     end
                  end else begin
                     lit_in   = '0;
                     phase_in = PH_LSETTLE;
                     count_in = to_time(cfg.settle_ticks);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (phase_in)
         PH_LSETTLE:                           color = COLOR_ORANGE;
         PH_SSTART, PH_SOVERLAP, PH_SPREFOCUS: color = COLOR_BLUE;
         PH_FOCUS:  color = (mode_in == MODE_SEQ) ? COLOR_BLUE : COLOR_GREEN;
         PH_PULSE, PH_SHUTWAIT:                color = COLOR_OFF;
         PH_AFTER:  color = (mode_in == MODE_SEQ) ? COLOR_BLUE : COLOR_PURPLE;
         default:                              color = COLOR_GREEN;
      endcase
   end

   assign result.led_mask     = MASK_W'(lit_in);
   assign result.focus_out    = focus_in;
   assign result.shutter_out  = shutter_in;
   assign result.busy_res     = (phase_in != PH_IDLE);
   assign result.status_color = color;
   assign result.error        = err;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            table_ff[i] <= '0;
         end
         last_nz_ff  <= '0;
         lit_ff      <= '0;
         phase_ff    <= PH_IDLE;
         count_ff    <= '0;
         step_ff     <= '0;
         mode_ff     <= MODE_LIGHT;
         target_ff   <= '0;
         focus_ff    <= 1'b0;
         shutter_ff  <= 1'b0;
         cur_led_ff  <= '0;
         prev_led_ff <= '0;
      end else if (accept) begin
         table_ff    <= table_in;
         last_nz_ff  <= last_nz_in;
         lit_ff      <= lit_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         step_ff     <= step_in;
         mode_ff     <= mode_in;
         target_ff   <= target_in;
         focus_ff    <= focus_in;
         shutter_ff  <= shutter_in;
         cur_led_ff  <= cur_led_in;
         prev_led_ff <= prev_led_in;
      end
   end

endmodule

// ----- hw/rtl/led_camera_capture_sequencer.sv -----
// Top level of the LED and camera capture sequencer.
// Depends on lccs_pkg and lccs_core; holds the timing registers and the
// result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_stall  | opcode, led_id, entry_index
//  rsp     | out       | rsp_valid/rsp_stall  | led_mask, camera lines, status
//  csr     | in        | csr_we               | csr_index, csr_wdata (24 bit)
//
// One transaction per cycle while req_stall is low; its result appears in the
// rsp register on the next cycle. Reset is synchronous: state, table and
// timing registers take their reset values together, with no clearing pass.
// req_stall is high only while a result is held in the rsp register under
// rsp_stall.
`timescale 1ns / 1ps

module led_camera_capture_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lccs_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lccs_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_we,
   input  logic [lccs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lccs_pkg::REG_W-1:0]           csr_wdata
);
   import lccs_pkg::*;

   timing_cfg_type  cfg_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type result;
   logic            accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   lccs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_payload),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overlap_ticks      <= '0;
         cfg_ff.prefocus_ticks     <= '0;
         cfg_ff.focus_ticks        <= '0;
         cfg_ff.shutter_wait_ticks <= '0;
         cfg_ff.after_ticks        <= '0;
         cfg_ff.pulse_ticks        <= PULSE_RESET;
         cfg_ff.settle_ticks       <= SETTLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OVERLAP:  cfg_ff.overlap_ticks      <= csr_wdata;
            CSR_PREFOCUS: cfg_ff.prefocus_ticks     <= csr_wdata;
            CSR_FOCUS:    cfg_ff.focus_ticks        <= csr_wdata;
            CSR_SHUTWAIT: cfg_ff.shutter_wait_ticks <= csr_wdata;
            CSR_AFTER:    cfg_ff.after_ticks        <= csr_wdata;
            CSR_PULSE:    cfg_ff.pulse_ticks        <= csr_wdata;
            CSR_SETTLE:   cfg_ff.settle_ticks       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for led_camera_capture_sequencer.
// Depends on lccs_pkg; a transaction-level predictor of the sequencer checks every
// response transaction under random valid/stall traffic.
`timescale 1ns / 1ps

module tb_top;
   import lccs_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int TIMING_ZERO  = 0;
   localparam int TIMING_SMALL = 1;
   localparam int TIMING_MAX   = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_wdata = '0;

   led_camera_capture_sequencer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   timing_cfg_type  timing;
   logic [3:0]      led_table [TABLE_DEPTH];
   logic [3:0]      table_end;
   logic [LIT_W-1:0] lamps;
   phase_type       cur_phase;
   logic [TIME_BITS-1:0] ticks_left;
   logic [3:0]      step;
   mode_type        cur_mode;
   logic [3:0]      target;
   logic            focus_lvl;
   logic            shutter_lvl;

   function automatic void lamp_write(logic [3:0] id, logic on);
      if (id != 0 && int'(id) <= MAX_LED) lamps[id - 4'd1] = on;
   endfunction

   function automatic void enter_phase(phase_type ph, logic [REG_W-1:0] d);
      cur_phase = ph;
      ticks_left = TIME_BITS'(d);
   endfunction

   function automatic void after_lamp_on();
      if (cur_mode == MODE_CAPTURE) begin
         focus_lvl = 1'b1;
         enter_phase(PH_FOCUS, timing.focus_ticks);
      end else if (cur_mode == MODE_FOCUS) begin
         enter_phase(PH_FSETTLE, timing.settle_ticks);
      end else begin
         enter_phase(PH_IDLE, '0);
      end
   endfunction

   function automatic void begin_light(mode_type mode, logic [3:0] led);
      cur_mode = mode;
      target = led;
      if (led != 0 && lamps[led - 4'd1]) begin
         after_lamp_on();
      end else begin
         lamps = '0;
         enter_phase(PH_LSETTLE, timing.settle_ticks);
      end
   endfunction

   // Applies one transaction to the predicted state and returns the outputs.
   function automatic rsp_payload_type predict_outputs(req_payload_type rq);
      rsp_payload_type r;
      error_type err;
      opcode_type op;
      color_type hue;
      op = opcode_type'(rq.opcode);
      err = ERR_NONE;
      if (op == OP_TICK) begin
         if (cur_phase != PH_IDLE) begin
            if (ticks_left > 1) begin
               ticks_left = ticks_left - 1'b1;
            end else begin
               case (cur_phase)
                  PH_LSETTLE: begin
                     lamp_write(target, 1'b1);
                     after_lamp_on();
                  end
                  PH_FSETTLE, PH_SPREFOCUS: begin
                     focus_lvl = 1'b1;
                     enter_phase(PH_FOCUS, timing.focus_ticks);
                  end
                  PH_SSTART: begin
                     step = '0;
                     lamp_write(led_table[0], 1'b1);
                     enter_phase(PH_SOVERLAP, timing.overlap_ticks);
                  end
                  PH_SOVERLAP: begin
                     if (step != 0) lamp_write(led_table[step - 4'd1], 1'b0);
                     enter_phase(PH_SPREFOCUS, timing.prefocus_ticks);
                  end
                  PH_FOCUS: begin
                     if (cur_mode == MODE_FOCUS) begin
                        focus_lvl = 1'b0;
                        shutter_lvl = 1'b0;
                        enter_phase(PH_IDLE, '0);
                     end else begin
                        shutter_lvl = 1'b1;
                        enter_phase(PH_PULSE, timing.pulse_ticks);
                     end
                  end
                  PH_PULSE: begin
                     shutter_lvl = 1'b0;
                     focus_lvl = 1'b0;
                     enter_phase(PH_SHUTWAIT, timing.shutter_wait_ticks);
                  end
                  PH_SHUTWAIT: enter_phase(PH_AFTER, timing.after_ticks);
                  PH_AFTER: begin
                     if (cur_mode == MODE_SEQ && step < table_end) begin
                        step = step + 4'd1;
                        lamp_write(led_table[step], 1'b1);
                        enter_phase(PH_SOVERLAP, timing.overlap_ticks);
                     end else begin
                        if (cur_mode == MODE_SEQ) lamp_write(led_table[table_end], 1'b0);
                        enter_phase(PH_IDLE, '0);
                     end
                  end
                  default: enter_phase(PH_IDLE, '0);
               endcase
            end
         end
      end else if (cur_phase != PH_IDLE) begin
         err = ERR_BUSY;
      end else begin
         case (op)
            OP_CLEAR: begin
               foreach (led_table[i]) led_table[i] = '0;
               table_end = '0;
            end
            OP_LOAD: begin
               if (int'(rq.entry_index) >= SEQ_DEPTH) begin
                  err = ERR_INDEX;
               end else if (int'(rq.led_id) > MAX_LED) begin
                  err = ERR_LED;
               end else begin
                  led_table[rq.entry_index] = rq.led_id;
                  table_end = '0;
                  for (int i = 0; i < SEQ_DEPTH; i++) begin
                     if (led_table[i] != 0) table_end = 4'(i);
                  end
               end
            end
            OP_SEQ: begin
               cur_mode = MODE_SEQ;
               step = '0;
               lamps = '0;
               enter_phase(PH_SSTART, timing.overlap_ticks);
            end
            OP_DARK: lamps = '0;
            default: begin
               if (int'(rq.led_id) > MAX_LED) err = ERR_LED;
               else if (op == OP_CAPTURE) begin_light(MODE_CAPTURE, rq.led_id);
               else if (op == OP_FOCUS) begin_light(MODE_FOCUS, rq.led_id);
               else begin_light(MODE_LIGHT, rq.led_id);
            end
         endcase
      end
      case (cur_phase)
         PH_LSETTLE: hue = COLOR_ORANGE;
         PH_SSTART, PH_SOVERLAP, PH_SPREFOCUS: hue = COLOR_BLUE;
         PH_FOCUS: hue = (cur_mode == MODE_SEQ) ? COLOR_BLUE : COLOR_GREEN;
         PH_PULSE, PH_SHUTWAIT: hue = COLOR_OFF;
         PH_AFTER: hue = (cur_mode == MODE_SEQ) ? COLOR_BLUE : COLOR_PURPLE;
         default: hue = COLOR_GREEN;
      endcase
      r.led_mask = MASK_W'(lamps);
      r.focus_out = focus_lvl;
      r.shutter_out = shutter_lvl;
      r.busy_res = (cur_phase != PH_IDLE);
      r.status_color = hue;
      r.error = err;
      return r;
   endfunction

   // ---------------------------------------------------------- driver/monitor
   req_payload_type pending_requests [$];
   rsp_payload_type predicted_outputs [$];
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  fail_count = 0;
   int  cycle_count = 0;
   int  queued_count = 0;
   logic req_taken = 1'b0;
   logic [3:0] plan_table [TABLE_DEPTH];

   // Acceptance: predict the response as each request transaction is taken.
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) predicted_outputs.push_back(predict_outputs(req_payload));
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_outputs.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_payload), 0);
         end else begin
            want = predicted_outputs.pop_front();
            if (rsp_payload.led_mask !== want.led_mask)
               report_mismatch("led_mask", 32'(rsp_payload.led_mask), 32'(want.led_mask));
            if (rsp_payload.focus_out !== want.focus_out)
               report_mismatch("focus_out", 32'(rsp_payload.focus_out), 32'(want.focus_out));
            if (rsp_payload.shutter_out !== want.shutter_out)
               report_mismatch("shutter_out", 32'(rsp_payload.shutter_out),
                               32'(want.shutter_out));
            if (rsp_payload.busy_res !== want.busy_res)
               report_mismatch("busy_res", 32'(rsp_payload.busy_res), 32'(want.busy_res));
            if (rsp_payload.status_color !== want.status_color)
               report_mismatch("status_color", 32'(rsp_payload.status_color),
                               32'(want.status_color));
            if (rsp_payload.error !== want.error)
               report_mismatch("error", 32'(rsp_payload.error), 32'(want.error));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // --------------------------------------------------------------- stimulus
   task automatic queue_cmd(opcode_type op, int led, int idx);
      req_payload_type rq;
      rq.opcode = op;
      rq.led_id = LED_ID_W'(led);
      rq.entry_index = IDX_W'(idx);
      pending_requests.push_back(rq);
      queued_count++;
   endtask

   task automatic queue_ticks(int n);
      repeat (n) queue_cmd(OP_TICK, $urandom_range(15), $urandom_range(15));
   endtask

   task automatic csr_write(csr_index_type ix, logic [REG_W-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= ix;
      csr_wdata <= v;
      case (ix)
         CSR_OVERLAP:  timing.overlap_ticks = v;
         CSR_PREFOCUS: timing.prefocus_ticks = v;
         CSR_FOCUS:    timing.focus_ticks = v;
         CSR_SHUTWAIT: timing.shutter_wait_ticks = v;
         CSR_AFTER:    timing.after_ticks = v;
         CSR_PULSE:    timing.pulse_ticks = v;
         CSR_SETTLE:   timing.settle_ticks = v;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [REG_W-1:0] timing_value(int kind);
      if (kind == TIMING_ZERO) return '0;
      if (kind == TIMING_MAX) return '1;
      return REG_W'($urandom_range(3));
   endfunction

   task automatic program_timing(int kind);
      csr_write(CSR_OVERLAP, timing_value(kind));
      csr_write(CSR_PREFOCUS, timing_value(kind));
      csr_write(CSR_FOCUS, timing_value(kind));
      csr_write(CSR_SHUTWAIT, timing_value(kind));
      csr_write(CSR_AFTER, timing_value(kind));
      csr_write(CSR_PULSE, timing_value(kind));
      csr_write(CSR_SETTLE, timing_value(kind));
      // unused index must not disturb anything
      csr_write(CSR_SPARE, REG_W'($urandom));
   endtask

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_valid || predicted_outputs.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mostly complete operations: a command followed by enough ticks to finish,
   // sometimes cut short by a command that lands while busy.
   task automatic queue_random_batch(int budget);
      int stop_at, r, led, idx, dmax, phases, ticks, cut, plan_end;
      opcode_type op;
      stop_at = queued_count + budget;
      dmax = 1;
      if (int'(timing.overlap_ticks) > dmax) dmax = int'(timing.overlap_ticks);
      if (int'(timing.prefocus_ticks) > dmax) dmax = int'(timing.prefocus_ticks);
      if (int'(timing.focus_ticks) > dmax) dmax = int'(timing.focus_ticks);
      if (int'(timing.shutter_wait_ticks) > dmax) dmax = int'(timing.shutter_wait_ticks);
      if (int'(timing.after_ticks) > dmax) dmax = int'(timing.after_ticks);
      if (int'(timing.pulse_ticks) > dmax) dmax = int'(timing.pulse_ticks);
      if (int'(timing.settle_ticks) > dmax) dmax = int'(timing.settle_ticks);
      while (queued_count < stop_at) begin
         r = $urandom_range(99);
         led = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
         idx = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
         if (r < 14) begin
            queue_cmd(OP_LOAD, led, idx);
            if (led <= MAX_LED) plan_table[idx] = 4'(led);
         end else if (r < 18) begin
            queue_cmd(OP_CLEAR, led, idx);
            foreach (plan_table[i]) plan_table[i] = '0;
         end else if (r < 22) begin
            queue_cmd(OP_DARK, led, idx);
         end else if (r < 25) begin
            queue_cmd(opcode_type'($urandom_range(7)), $urandom_range(15), $urandom_range(15));
         end else begin
            plan_end = 0;
            foreach (plan_table[i]) if (plan_table[i] != 0) plan_end = i;
            if (r < 45) begin
               op = OP_LIGHT;
               phases = 1;
            end else if (r < 65) begin
               op = OP_CAPTURE;
               phases = 5;
            end else if (r < 80) begin
               op = OP_FOCUS;
               phases = 3;
            end else begin
               op = OP_SEQ;
               phases = 1 + 6 * (plan_end + 1);
            end
            queue_cmd(op, led, idx);
            ticks = phases * dmax + $urandom_range(2);
            if ($urandom_range(4) == 0) begin
               cut = $urandom_range(ticks);
               queue_ticks(cut);
               queue_cmd(opcode_type'($urandom_range(7, 1)), $urandom_range(15),
                         $urandom_range(15));
               ticks = ticks - cut;
            end
            queue_ticks(ticks);
         end
      end
   endtask

   initial begin
      timing.overlap_ticks = '0;
      timing.prefocus_ticks = '0;
      timing.focus_ticks = '0;
      timing.shutter_wait_ticks = '0;
      timing.after_ticks = '0;
      timing.pulse_ticks = PULSE_RESET;
      timing.settle_ticks = SETTLE_RESET;
      foreach (led_table[i]) led_table[i] = '0;
      foreach (plan_table[i]) plan_table[i] = '0;
      table_end = '0;
      lamps = '0;
      cur_phase = PH_IDLE;
      ticks_left = '0;
      step = '0;
      cur_mode = MODE_LIGHT;
      target = '0;
      focus_lvl = 1'b0;
      shutter_lvl = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: every phase lasts a single tick
      program_timing(TIMING_ZERO);
      queue_cmd(OP_TICK, 0, 0);
      queue_cmd(OP_DARK, 0, 0);
      queue_cmd(OP_LOAD, 8, 0);
      queue_cmd(OP_LOAD, 9, 15);
      queue_cmd(OP_LIGHT, 15, 0);
      queue_cmd(OP_CAPTURE, 9, 0);
      queue_cmd(OP_FOCUS, 12, 0);
      queue_cmd(OP_LIGHT, 8, 0);
      queue_cmd(OP_CAPTURE, 1, 15);
      queue_cmd(OP_TICK, 15, 15);
      queue_cmd(OP_CAPTURE, 8, 0);   // already lit: straight to focus
      queue_ticks(4);
      queue_cmd(OP_FOCUS, 8, 0);     // already lit: settle, then focus
      queue_ticks(2);
      queue_cmd(OP_SEQ, 0, 0);
      queue_ticks(7);
      queue_cmd(OP_CLEAR, 0, 0);
      queue_cmd(OP_LIGHT, 0, 0);     // no LED: all off and settle
      queue_cmd(OP_TICK, 0, 0);
      wait_until_drained();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 84 : 0;
         recv_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 16 : 0;
         for (int k = 0; k < 2; k++) begin
            program_timing((mode == 2 && k == 0) ? TIMING_ZERO : TIMING_SMALL);
            queue_random_batch(210);
            wait_until_drained();
         end
      end

      // longest delays: the light settle outlasts the rest of the run
      program_timing(TIMING_MAX);
      queue_cmd(OP_DARK, 0, 0);
      queue_cmd(OP_LOAD, 5, 2);
      queue_cmd(OP_LIGHT, 5, 0);
      queue_ticks(20);
      queue_cmd(OP_CAPTURE, 1, 0);
      queue_cmd(OP_SEQ, 0, 0);
      queue_cmd(OP_TICK, 0, 0);
      wait_until_drained();
      repeat (10) @(negedge clock);

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
